>>> src/ps2mct_pkg.sv
// shared types and constants for the ps/2 mouse cursor tracker
`default_nettype none

package ps2mct_pkg;

  // fixed field widths
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register reset values
  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;
  localparam logic [TAG_W-1:0] RESET_TAG = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_MOTION_FROZEN = 3'd2,
    CFG_REPORT_ENABLE = 3'd3,
    CFG_REPORT_TAG    = 3'd4
  } cfg_idx_e;

  // place of a byte inside a packet
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_DX     = 2'd1,
    POS_DY     = 2'd2
  } byte_pos_e;

  // header byte bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_X_SIGN = 4;
  localparam int unsigned HDR_Y_SIGN = 5;
  localparam int unsigned HDR_X_OVF  = 6;
  localparam int unsigned HDR_Y_OVF  = 7;

  // per-axis move control
  typedef struct packed {
    logic apply;     // delta is applied this byte
    logic negative;  // sign bit of the nine-bit delta
    logic subtract;  // axis runs against the delta
  } axis_ctrl_t;

endpackage

`default_nettype wire

>>> src/ps2mct_axis.sv
// one cursor axis: apply a signed delta and clamp to the screen size
`default_nettype none

module ps2mct_axis #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]       pos_i,
  input  logic [ps2mct_pkg::BYTE_W-1:0] byte_i,
  input  ps2mct_pkg::axis_ctrl_t      ctrl_i,
  input  logic [ps2mct_pkg::SIZE_W-1:0] size_i,
  output logic [COORD_BITS-1:0]       pos_o
);
  import ps2mct_pkg::*;

  localparam int unsigned KW = ((COORD_BITS + 2) > (SIZE_W + 1)) ? (COORD_BITS + 2) : (SIZE_W + 1);
  localparam logic signed [KW-1:0] LIMIT = KW'(1) << COORD_BITS;
  localparam logic signed [KW-1:0] ONE   = KW'(1);

  logic signed [KW-1:0] delta;
  logic signed [KW-1:0] cur;
  logic signed [KW-1:0] moved;
  logic signed [KW-1:0] size_sat;
  logic signed [KW-1:0] hi;

  // sign-extend the delta, zero-extend the position
  assign delta = {{(KW-BYTE_W){ctrl_i.negative}}, byte_i};
  assign cur   = {{(KW-COORD_BITS){1'b0}}, pos_i};

  // move
  always_comb begin
    if (!ctrl_i.apply) begin
      moved = cur;
    end else if (ctrl_i.subtract) begin
      moved = cur - delta;
    end else begin
      moved = cur + delta;
    end
  end

  // upper bound: zero size acts as one, oversize saturates
  always_comb begin
    size_sat = {{(KW-SIZE_W){1'b0}}, size_i};
    if (size_sat == '0) begin
      size_sat = ONE;
    end else if (size_sat > LIMIT) begin
      size_sat = LIMIT;
    end
    hi = size_sat - ONE;
  end

  // clamp
  always_comb begin
    if (moved < 0) begin
      pos_o = '0;
    end else if (moved > hi) begin
      pos_o = hi[COORD_BITS-1:0];
    end else begin
      pos_o = moved[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/ps2_mouse_cursor_tracker_top.sv
// ps/2 mouse packet decoder that tracks a clamped cursor position
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid_i/in_stall_o  | data_byte_i
//  out     | out | out_valid_o/out_stall_i| cursor_x/y, buttons, report_valid/label
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one byte per cycle while input is not stalled; each byte's result is registered,
// the add and clamp of one axis sits between the packet state and the result register.
// a two-entry output (result register plus skid) keeps input open while a result waits;
// input stalls only when both entries are full.
// reset (rst_ni low, async) clears the packet counter, buttons and flags and puts the
// cursor at half the reset screen size; cfg writes are always ready.
`default_nettype none

module ps2_mouse_cursor_tracker_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ps2mct_pkg::BYTE_W-1:0]  data_byte_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [COORD_BITS-1:0]          cursor_x_o,
  output logic [COORD_BITS-1:0]          cursor_y_o,
  output logic                           button_left_o,
  output logic                           button_middle_o,
  output logic                           button_right_o,
  output logic                           report_valid_o,
  output logic [ps2mct_pkg::TAG_W-1:0]   report_label_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ps2mct_pkg::SIZE_W-1:0]  cfg_data_i
);
  import ps2mct_pkg::*;

  localparam int unsigned CMAX   = (1 << COORD_BITS) - 1;
  localparam int unsigned HALF_W = RESET_WIDTH / 2;
  localparam int unsigned HALF_H = RESET_HEIGHT / 2;
  localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'((HALF_W > CMAX) ? CMAX : HALF_W);
  localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'((HALF_H > CMAX) ? CMAX : HALF_H);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  middle;
    logic                  right;
    logic                  rep;
    logic [TAG_W-1:0]      label;
  } result_t;

  // configuration registers
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic              frozen_q;
  logic              rep_en_q;
  logic [TAG_W-1:0]  tag_q;

  // packet state
  byte_pos_e             pos_q, pos_d;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [2:0]            btn_q, btn_d;
  logic [3:0]            so_q, so_d;   // x sign, y sign, x ovf, y ovf

  // output stage
  logic    out_valid_q, sk_valid_q;
  result_t out_q, sk_q;
  result_t res;

  logic in_accept, out_take;
  logic [COORD_BITS-1:0] x_new, y_new;
  axis_ctrl_t x_ctrl, y_ctrl;
  logic third;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = sk_valid_q;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;

  // config write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(RESET_WIDTH);
      height_q <= SIZE_W'(RESET_HEIGHT);
      frozen_q <= 1'b0;
      rep_en_q <= 1'b0;
      tag_q    <= RESET_TAG;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        CFG_MOTION_FROZEN: frozen_q <= cfg_data_i[0];
        CFG_REPORT_ENABLE: rep_en_q <= cfg_data_i[0];
        CFG_REPORT_TAG:    tag_q    <= cfg_data_i[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // byte decode
  always_comb begin
    btn_d  = btn_q;
    so_d   = so_q;
    third  = 1'b0;
    x_ctrl = '{apply: 1'b0, negative: so_q[0], subtract: 1'b0};
    y_ctrl = '{apply: 1'b0, negative: so_q[1], subtract: 1'b1};
    pos_d  = POS_HEADER;
    unique case (pos_q)
      POS_HEADER: begin
        btn_d = data_byte_i[HDR_MIDDLE:HDR_LEFT];
        so_d  = data_byte_i[HDR_Y_OVF:HDR_X_SIGN];
        pos_d = POS_DX;
      end
      POS_DX: begin
        x_ctrl.apply = !so_q[2] && !frozen_q;
        pos_d        = POS_DY;
      end
      default: begin
        third        = 1'b1;
        y_ctrl.apply = !so_q[3] && !frozen_q;
        pos_d        = POS_HEADER;
      end
    endcase
  end

  ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos_i  (x_q),
    .byte_i (data_byte_i),
    .ctrl_i (x_ctrl),
    .size_i (width_q),
    .pos_o  (x_new)
  );

  ps2mct_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos_i  (y_q),
    .byte_i (data_byte_i),
    .ctrl_i (y_ctrl),
    .size_i (height_q),
    .pos_o  (y_new)
  );

  // result of this beat
  always_comb begin
    res.x      = x_new;
    res.y      = y_new;
    res.left   = btn_d[HDR_LEFT];
    res.middle = btn_d[HDR_MIDDLE];
    res.right  = btn_d[HDR_RIGHT];
    res.rep    = third && rep_en_q && !frozen_q;
    res.label  = res.rep ? tag_q : '0;
  end

  // packet state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HEADER;
      x_q   <= RESET_X;
      y_q   <= RESET_Y;
      btn_q <= '0;
      so_q  <= '0;
    end else if (in_accept) begin
      pos_q <= pos_d;
      x_q   <= x_new;
      y_q   <= y_new;
      btn_q <= btn_d;
      so_q  <= so_d;
    end
  end

  // output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      if (sk_valid_q) begin
        if (out_take) begin
          sk_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid_q && !out_take) begin
          sk_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (sk_valid_q) begin
      if (out_take) begin
        out_q <= sk_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        sk_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_x_o      = out_q.x;
  assign cursor_y_o      = out_q.y;
  assign button_left_o   = out_q.left;
  assign button_middle_o = out_q.middle;
  assign button_right_o  = out_q.right;
  assign report_valid_o  = out_q.rep;
  assign report_label_o  = out_q.label;

`ifndef SYNTHESIS
  // skid never holds a beat without the result register holding one
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // a beat arriving behind a stalled result lands in the skid
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && in_accept) |=> sk_valid_q)
    else $error("beat lost behind stalled result");

  // output drains when taken with nothing behind it
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !sk_valid_q && !in_accept) |=> !out_valid_q)
    else $error("result repeated after it was taken");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
// testbench for the ps/2 mouse cursor tracker: directed and random bytes checked by a predictor
`timescale 1ns / 100ps

module tb;
  import ps2mct_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int RANDOM_ITEMS = 1200;
  localparam int RANDOM_PHASES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // one result beat as the block should present it
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  middle;
    logic                  right;
    logic                  report;
    logic [TAG_W-1:0]      label;
  } cursor_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic                  cfg_ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic                  button_left;
  logic                  button_middle;
  logic                  button_right;
  logic                  report_valid;
  logic [TAG_W-1:0]      report_label;

  // register copies
  logic [SIZE_W-1:0] width_cfg;
  logic [SIZE_W-1:0] height_cfg;
  logic              frozen_cfg;
  logic              enable_cfg;
  logic [TAG_W-1:0]  tag_cfg;

  // packet tracking state of the predictor
  byte_pos_e             trk_pos = POS_HEADER;
  logic [COORD_BITS-1:0] trk_x = COORD_BITS'(RESET_WIDTH / 2);
  logic [COORD_BITS-1:0] trk_y = COORD_BITS'(RESET_HEIGHT / 2);
  logic [BYTE_W-1:0]     trk_header = '0;

  logic [BYTE_W-1:0] mouse_byte_q[$];
  cursor_res_t       pending_cursor_q[$];
  cursor_res_t       next_cursor;

  logic send_calm;
  logic recv_calm;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   recv_draw;
  int   mismatch_count = 0;
  int unsigned cycle_count = 0;

  ps2_mouse_cursor_tracker_top #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .cursor_x_o     (cursor_x),
    .cursor_y_o     (cursor_y),
    .button_left_o  (button_left),
    .button_middle_o(button_middle),
    .button_right_o (button_right),
    .report_valid_o (report_valid),
    .report_label_o (report_label),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ps2_mouse_cursor_tracker_top test failed");
      $finish;
    end
  end

  function automatic int idle_draw(logic calm);
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  // zero size acts as one, sizes past the coordinate range saturate
  function automatic logic [COORD_BITS-1:0] clamp_to_screen(int v, logic [SIZE_W-1:0] size);
    int s;
    s = int'(size);
    if (s == 0) s = 1;
    if (s > (1 << COORD_BITS)) s = 1 << COORD_BITS;
    if (v < 0) return '0;
    if (v > s - 1) return COORD_BITS'(s - 1);
    return COORD_BITS'(v);
  endfunction

  function automatic int signed_delta(logic [BYTE_W-1:0] b, logic negative);
    int d;
    d = int'(b);
    if (negative) d -= 256;
    return d;
  endfunction

  // advance the packet state by one byte and queue the cursor it should give
  function automatic void track_cursor(logic [BYTE_W-1:0] b);
    int x;
    int y;
    logic report;
    cursor_res_t res;
    x = int'(trk_x);
    y = int'(trk_y);
    report = 1'b0;
    case (trk_pos)
      POS_HEADER: begin
        trk_header = b;
        trk_pos = POS_DX;
      end
      POS_DX: begin
        if (!trk_header[HDR_X_OVF] && !frozen_cfg)
          x += signed_delta(b, trk_header[HDR_X_SIGN]);
        trk_pos = POS_DY;
      end
      default: begin
        if (!trk_header[HDR_Y_OVF] && !frozen_cfg)
          y -= signed_delta(b, trk_header[HDR_Y_SIGN]);
        report = enable_cfg && !frozen_cfg;
        trk_pos = POS_HEADER;
      end
    endcase
    trk_x = clamp_to_screen(x, width_cfg);
    trk_y = clamp_to_screen(y, height_cfg);
    res.x = trk_x;
    res.y = trk_y;
    res.left = trk_header[HDR_LEFT];
    res.middle = trk_header[HDR_MIDDLE];
    res.right = trk_header[HDR_RIGHT];
    res.report = report;
    res.label = report ? tag_cfg : '0;
    pending_cursor_q.push_back(res);
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      data_byte <= '0;
      send_wait <= 0;
      trk_pos = POS_HEADER;
      trk_x = COORD_BITS'(RESET_WIDTH / 2);
      trk_y = COORD_BITS'(RESET_HEIGHT / 2);
      trk_header = '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) track_cursor(data_byte);
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_valid <= 1'b0;
      end else if (mouse_byte_q.size() != 0) begin
        data_byte <= mouse_byte_q.pop_front();
        in_valid <= 1'b1;
        send_wait <= idle_draw(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_cursor_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing pending, expected none, actual x %0d y %0d",
                 $time, cursor_x, cursor_y);
      end else begin
        next_cursor = pending_cursor_q.pop_front();
        check_field("cursor_x", 32'(next_cursor.x), 32'(cursor_x));
        check_field("cursor_y", 32'(next_cursor.y), 32'(cursor_y));
        check_field("button_left", 32'(next_cursor.left), 32'(button_left));
        check_field("button_middle", 32'(next_cursor.middle), 32'(button_middle));
        check_field("button_right", 32'(next_cursor.right), 32'(button_right));
        check_field("report_valid", 32'(next_cursor.report), 32'(report_valid));
        check_field("report_label", 32'(next_cursor.label), 32'(report_label));
      end
      recv_draw = idle_draw(recv_calm);
      recv_wait <= recv_draw;
      out_stall <= (recv_draw != 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_stall <= (recv_wait != 1);
    end
  end

  task automatic push_packet(logic [BYTE_W-1:0] header, logic [BYTE_W-1:0] dx,
                             logic [BYTE_W-1:0] dy);
    mouse_byte_q.push_back(header);
    mouse_byte_q.push_back(dx);
    mouse_byte_q.push_back(dy);
  endtask

  // mostly whole packets, now and then a stray byte that shifts the framing
  task automatic push_random(int n);
    int count;
    logic [BYTE_W-1:0] header;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 19) == 0) begin
        mouse_byte_q.push_back(BYTE_W'($urandom));
        count++;
      end else begin
        header = BYTE_W'($urandom);
        if ($urandom_range(0, 7) != 0) begin
          header[HDR_X_OVF] = 1'b0;
          header[HDR_Y_OVF] = 1'b0;
        end
        push_packet(header, BYTE_W'($urandom), BYTE_W'($urandom));
        count += 3;
      end
    end
  endtask

  // wait until every byte is sent and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (mouse_byte_q.size() != 0 || in_valid || pending_cursor_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCREEN_WIDTH:  width_cfg = value;
      CFG_SCREEN_HEIGHT: height_cfg = value;
      CFG_MOTION_FROZEN: frozen_cfg = value[0];
      CFG_REPORT_ENABLE: enable_cfg = value[0];
      CFG_REPORT_TAG:    tag_cfg = value[TAG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return SIZE_W'($urandom_range(1, 16));
      1: return SIZE_W'($urandom_range(17, 1024));
      2: return SIZE_W'(1 << COORD_BITS);
      3: return SIZE_W'($urandom_range((1 << COORD_BITS) + 1, (1 << SIZE_W) - 1));
      4: return '0;
      default: return SIZE_W'($urandom_range(1, 1 << COORD_BITS));
    endcase
  endfunction

  // stimulus
  initial begin
    width_cfg = SIZE_W'(RESET_WIDTH);
    height_cfg = SIZE_W'(RESET_HEIGHT);
    frozen_cfg = 1'b0;
    enable_cfg = 1'b0;
    tag_cfg = RESET_TAG;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: all buttons, full-scale deltas, sign and overflow bits
    push_packet(8'h07, 8'hFF, 8'hFF);
    push_packet(8'h3A, 8'h00, 8'h00);
    push_packet(8'hC5, 8'h7F, 8'h80);
    wait_idle();

    // reporting on; writes past the last register are dropped
    write_reg(CFG_REPORT_ENABLE, 13'd1);
    write_reg(CFG_REPORT_TAG, 13'h05A);
    for (int i = CFG_REPORT_TAG + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), '1);
    push_packet(8'h00, 8'h10, 8'hF0);
    wait_idle();

    // frozen motion: no movement and no report
    write_reg(CFG_MOTION_FROZEN, 13'd1);
    push_packet(8'h19, 8'h40, 8'h40);
    wait_idle();

    // zero and one-pixel screens pin the cursor at the origin
    write_reg(CFG_MOTION_FROZEN, 13'd0);
    write_reg(CFG_SCREEN_WIDTH, 13'd0);
    write_reg(CFG_SCREEN_HEIGHT, 13'd1);
    push_packet(8'h00, 8'h05, 8'h05);
    wait_idle();

    // oversized screen saturates to the coordinate range
    write_reg(CFG_SCREEN_WIDTH, 13'h1FFF);
    write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
    write_reg(CFG_REPORT_TAG, 13'h0A5);
    push_packet(8'h20, 8'hFF, 8'h00);
    wait_idle();

    // shrunk screen pulls the cursor in at the next byte
    write_reg(CFG_SCREEN_WIDTH, 13'd100);
    write_reg(CFG_SCREEN_HEIGHT, 13'd50);
    push_packet(8'h08, 8'h00, 8'h00);
    wait_idle();

    // random phases, each with fresh settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_SCREEN_WIDTH, pick_size());
      write_reg(CFG_SCREEN_HEIGHT, pick_size());
      write_reg(CFG_MOTION_FROZEN, {12'($urandom), 1'($urandom_range(0, 3) == 0)});
      write_reg(CFG_REPORT_ENABLE, {12'($urandom), 1'($urandom)});
      write_reg(CFG_REPORT_TAG, SIZE_W'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_REPORT_TAG + 1, (1 << CFG_IDX_W) - 1)),
                  SIZE_W'($urandom));
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      push_random(RANDOM_ITEMS / (2 * RANDOM_PHASES));
      // in phase 3 the sender holds off mid-phase until the block has drained
      if (ph == 3) wait_idle();
      push_random(RANDOM_ITEMS / (2 * RANDOM_PHASES));
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("ps2_mouse_cursor_tracker_top test passed");
    else
      $display("ps2_mouse_cursor_tracker_top test failed");
    $finish;
  end

endmodule
